// ===== rtl/core/tcb_pkg.sv =====
package tcb_pkg;

   // Input command codes (carried in req_tuser)
   localparam logic [1:0] CMD_CHAR  = 2'd0;
   localparam logic [1:0] CMD_KEY   = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;
   localparam logic [1:0] CMD_READ  = 2'd3;

   // Control characters
   localparam logic [7:0] CH_BS  = 8'd8;
   localparam logic [7:0] CH_TAB = 8'd9;
   localparam logic [7:0] CH_LF  = 8'd10;
   localparam logic [7:0] CH_CR  = 8'd13;
   localparam logic [7:0] CH_ESC = 8'd27;
   localparam logic [7:0] BLANK  = 8'h20;

   // Navigation key codes
   localparam logic [3:0] KEY_HOME   = 4'd0;
   localparam logic [3:0] KEY_END    = 4'd1;
   localparam logic [3:0] KEY_PGUP   = 4'd2;
   localparam logic [3:0] KEY_PGDN   = 4'd3;
   localparam logic [3:0] KEY_LEFT   = 4'd4;
   localparam logic [3:0] KEY_RIGHT  = 4'd5;
   localparam logic [3:0] KEY_UP     = 4'd6;
   localparam logic [3:0] KEY_DOWN   = 4'd7;
   localparam logic [3:0] KEY_DELETE = 4'd8;

   // Register indexes and reset values
   localparam logic [1:0] REG_COLUMNS   = 2'd0;
   localparam logic [1:0] REG_ROWS      = 2'd1;
   localparam logic [7:0] COLUMNS_RESET = 8'd80;
   localparam logic [6:0] ROWS_RESET    = 7'd25;

   // Classified operation handed from the front end to the executor
   typedef enum logic [4:0] {
      OP_PUT, OP_BS, OP_TAB, OP_LF, OP_CR, OP_CLEAR,
      OP_HOME, OP_END, OP_PGUP, OP_PGDN, OP_LEFT, OP_RIGHT, OP_UP, OP_DOWN,
      OP_DEL, OP_READ, OP_NOP
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  ch;
      logic [6:0]  rd_col;
      logic [5:0]  rd_row;
   } op_type;

   // One result beat
   typedef struct packed {
      logic       span_valid;
      logic [5:0] span_row;
      logic [6:0] span_col;
      logic [7:0] span_len;
      logic       clear_all;
      logic [6:0] caret_col;
      logic [5:0] caret_row;
      logic [7:0] read_char;
   } rsp_type;

   // Executor sequencer
   typedef enum logic [2:0] {
      ST_IDLE, ST_CHECK, ST_FILL, ST_RUN, ST_TAB, ST_DEL, ST_DEL_END, ST_READ
   } state_type;

endpackage

// ===== rtl/core/tcb_front.sv =====
module tcb_front (
   input  logic           req_tvalid,
   input  logic [1:0]     req_tuser,
   input  logic [31:0]    req_tdata,
   output logic           req_tready,
   input  logic           q_full,
   output logic           push,
   output tcb_pkg::op_type push_op
);
   import tcb_pkg::*;

   logic [7:0] char_code;
   logic [3:0] key_code;

   assign char_code  = req_tdata[7:0];
   assign key_code   = req_tdata[11:8];
   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;

   // Classify the beat into one executor operation
   always_comb begin
      push_op.ch     = char_code;
      push_op.rd_col = req_tdata[18:12];
      push_op.rd_row = req_tdata[24:19];
      push_op.kind   = OP_NOP;
      unique case (req_tuser)
         CMD_CHAR: begin
            case (char_code)
               CH_BS:   push_op.kind = OP_BS;
               CH_TAB:  push_op.kind = OP_TAB;
               CH_LF:   push_op.kind = OP_LF;
               CH_CR:   push_op.kind = OP_CR;
               CH_ESC:  push_op.kind = OP_CLEAR;
               default: push_op.kind = OP_PUT;
            endcase
         end
         CMD_KEY: begin
            unique case (key_code)
               KEY_HOME:   push_op.kind = OP_HOME;
               KEY_END:    push_op.kind = OP_END;
               KEY_PGUP:   push_op.kind = OP_PGUP;
               KEY_PGDN:   push_op.kind = OP_PGDN;
               KEY_LEFT:   push_op.kind = OP_LEFT;
               KEY_RIGHT:  push_op.kind = OP_RIGHT;
               KEY_UP:     push_op.kind = OP_UP;
               KEY_DOWN:   push_op.kind = OP_DOWN;
               KEY_DELETE: push_op.kind = OP_DEL;
               default:    push_op.kind = OP_NOP;
            endcase
         end
         CMD_CLEAR: push_op.kind = OP_CLEAR;
         CMD_READ:  push_op.kind = OP_READ;
         default:   push_op.kind = OP_NOP;
      endcase
   end

endmodule

// ===== rtl/core/tcb_queue.sv =====
module tcb_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  tcb_pkg::op_type push_op,
   input  logic            pop,
   output logic            full,
   output logic            valid,
   output tcb_pkg::op_type head
);
   import tcb_pkg::*;

   op_type     slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign valid = (count_ff != 2'd0);
   assign head  = slot_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ===== rtl/core/tcb_back.sv =====
module tcb_back #(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64,
   parameter int TAB_STOP = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   input  logic [1:0]       csr_index,
   input  logic [7:0]       csr_data,
   output logic             csr_ready,
   input  logic             q_valid,
   input  tcb_pkg::op_type  q_op,
   output logic             q_pop,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output tcb_pkg::rsp_type rsp
);
   import tcb_pkg::*;

   localparam int CW       = $clog2(MAX_COLS);
   localparam int RW       = $clog2(MAX_ROWS);
   localparam int ColSlots = 2 ** CW;
   localparam int MemDepth = 2 ** (CW + RW);

   state_type        state_ff, state_in;
   op_type           op_ff, op_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [7:0]       columns_ff, columns_in;
   logic [6:0]       rows_ff, rows_in;
   logic [MAX_ROWS-1:0] rv_ff, rv_in;
   logic [CW-1:0]    fill_ff, fill_in;
   logic [CW:0]      src_ff, src_in;
   logic [CW-1:0]    dst_ff, dst_in;
   logic             pend_ff, pend_in;
   logic [RW-1:0]    span_row_ff, span_row_in;
   logic [CW-1:0]    span_col_ff, span_col_in;
   logic [CW:0]      len_ff, len_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   // Cell store, rows gated by row valid bits
   logic [7:0]       cell_mem [MemDepth];
   logic [7:0]       rdata_ff;
   logic             mem_we;
   logic [CW+RW-1:0] mem_waddr, mem_raddr;
   logic [7:0]       mem_wdata;

   logic [CW:0]      nc;
   logic [RW:0]      nr;
   logic [CW:0]      col_p1;
   logic [RW:0]      row_p1;
   logic [RW-1:0]    line_next;
   logic             wrap;
   logic [CW-1:0]    adv_col;
   logic [RW-1:0]    adv_row;
   logic             tab_end;
   logic             out_free;
   logic             needs_row;
   logic             rd_in;
   logic             rd_hit;
   logic [CW-1:0]    rd_col_t;
   logic [RW-1:0]    rd_row_t;
   logic             cfg_hit;
   logic [ColSlots-1:0] tab_stop;

   // Result temporaries
   logic             res_load;
   logic             res_sv;
   logic             res_clr;
   logic [RW-1:0]    res_srow;
   logic [CW-1:0]    res_scol;
   logic [CW:0]      res_slen;
   logic [7:0]       res_rd;

   // Tab stop columns, worked out at elaboration
   for (genvar g = 0; g < ColSlots; g++) begin : g_tab
      localparam int StopRem = g % TAB_STOP;
      assign tab_stop[g] = (StopRem == 0);
   end

   // Active grid size, clamped to the store
   always_comb begin
      if (columns_ff == 8'd0) begin
         nc = (CW+1)'(1);
      end else if (int'(columns_ff) > MAX_COLS) begin
         nc = (CW+1)'(MAX_COLS);
      end else begin
         nc = (CW+1)'(columns_ff);
      end
      if (rows_ff == 7'd0) begin
         nr = (RW+1)'(1);
      end else if (int'(rows_ff) > MAX_ROWS) begin
         nr = (RW+1)'(MAX_ROWS);
      end else begin
         nr = (RW+1)'(rows_ff);
      end
   end

   // Caret advance with row wrap
   assign col_p1    = {1'b0, col_ff} + (CW+1)'(1);
   assign row_p1    = {1'b0, row_ff} + (RW+1)'(1);
   assign line_next = (row_p1 >= nr) ? '0 : row_p1[RW-1:0];
   assign wrap      = (col_p1 >= nc);
   assign adv_col   = wrap ? '0 : col_p1[CW-1:0];
   assign adv_row   = wrap ? line_next : row_ff;
   assign tab_end   = wrap || tab_stop[adv_col];

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign needs_row = (op_ff.kind inside {OP_PUT, OP_TAB, OP_DEL})
                   || ((op_ff.kind == OP_BS) && (col_ff != '0));
   assign rd_in     = (int'(op_ff.rd_col) < MAX_COLS) && (int'(op_ff.rd_row) < MAX_ROWS);
   assign rd_col_t  = CW'(op_ff.rd_col);
   assign rd_row_t  = RW'(op_ff.rd_row);
   assign rd_hit    = rd_in && rv_ff[rd_row_t];

   // Register writes are taken only with the executor idle and no event queued
   assign csr_ready = (state_ff == ST_IDLE) && !q_valid;
   assign cfg_hit   = csr_valid && csr_ready
                   && ((csr_index == REG_COLUMNS) || (csr_index == REG_ROWS));

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && out_free) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = (needs_row && !rv_ff[row_ff]) ? ST_FILL : ST_RUN;
         end
         ST_FILL: begin
            if (fill_ff == CW'(MAX_COLS - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            unique case (op_ff.kind)
               OP_TAB:  state_in = ST_TAB;
               OP_BS:   state_in = (col_ff != '0) ? ST_DEL : ST_IDLE;
               OP_DEL:  state_in = ST_DEL;
               OP_READ: state_in = rd_hit ? ST_READ : ST_IDLE;
               default: state_in = ST_IDLE;
            endcase
         end
         ST_TAB: begin
            if (tab_end) begin
               state_in = ST_IDLE;
            end
         end
         ST_DEL: begin
            if (src_ff >= nc) begin
               state_in = ST_DEL_END;
            end
         end
         ST_DEL_END: state_in = ST_IDLE;
         ST_READ:    state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Datapath, store and result control
   always_comb begin
      op_in        = op_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      columns_in   = columns_ff;
      rows_in      = rows_ff;
      rv_in        = rv_ff;
      fill_in      = fill_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      pend_in      = pend_ff;
      span_row_in  = span_row_ff;
      span_col_in  = span_col_ff;
      len_in       = len_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = {row_ff, col_ff};
      mem_wdata    = BLANK;
      mem_raddr    = {row_ff, col_ff};
      res_load     = 1'b0;
      res_sv       = 1'b0;
      res_clr      = 1'b0;
      res_srow     = '0;
      res_scol     = '0;
      res_slen     = '0;
      res_rd       = 8'd0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               op_in = q_op;
            end
         end
         ST_CHECK: begin
            fill_in = '0;
         end
         ST_FILL: begin
            // blank the row once before its first write after a clear
            mem_we    = 1'b1;
            mem_waddr = {row_ff, fill_ff};
            fill_in   = fill_ff + CW'(1);
            if (fill_ff == CW'(MAX_COLS - 1)) begin
               rv_in[row_ff] = 1'b1;
            end
         end
         ST_RUN: begin
            unique case (op_ff.kind)
               OP_PUT: begin
                  mem_we    = 1'b1;
                  mem_wdata = op_ff.ch;
                  col_in    = adv_col;
                  row_in    = adv_row;
                  res_load  = 1'b1;
                  res_sv    = 1'b1;
                  res_srow  = row_ff;
                  res_scol  = col_ff;
                  res_slen  = (CW+1)'(1);
               end
               OP_TAB: begin
                  span_row_in = row_ff;
                  span_col_in = col_ff;
                  len_in      = '0;
               end
               OP_BS: begin
                  if (col_ff != '0) begin
                     col_in      = col_ff - CW'(1);
                     span_row_in = row_ff;
                     span_col_in = col_ff - CW'(1);
                     src_in      = {1'b0, col_ff};
                     pend_in     = 1'b0;
                  end else begin
                     res_load = 1'b1;
                  end
               end
               OP_DEL: begin
                  span_row_in = row_ff;
                  span_col_in = col_ff;
                  src_in      = col_p1;
                  pend_in     = 1'b0;
               end
               OP_LF: begin
                  row_in   = line_next;
                  res_load = 1'b1;
               end
               OP_CR: begin
                  col_in   = '0;
                  row_in   = line_next;
                  res_load = 1'b1;
               end
               OP_CLEAR: begin
                  rv_in    = '0;
                  col_in   = '0;
                  row_in   = '0;
                  res_load = 1'b1;
                  res_clr  = 1'b1;
               end
               OP_HOME: begin
                  col_in   = '0;
                  res_load = 1'b1;
               end
               OP_END: begin
                  col_in   = CW'(nc - (CW+1)'(1));
                  res_load = 1'b1;
               end
               OP_PGUP: begin
                  row_in   = '0;
                  res_load = 1'b1;
               end
               OP_PGDN: begin
                  row_in   = RW'(nr - (RW+1)'(1));
                  res_load = 1'b1;
               end
               OP_LEFT: begin
                  if (col_ff != '0) begin
                     col_in = col_ff - CW'(1);
                  end
                  res_load = 1'b1;
               end
               OP_RIGHT: begin
                  if (col_p1 < nc) begin
                     col_in = col_p1[CW-1:0];
                  end
                  res_load = 1'b1;
               end
               OP_UP: begin
                  if (row_ff != '0) begin
                     row_in = row_ff - RW'(1);
                  end
                  res_load = 1'b1;
               end
               OP_DOWN: begin
                  if (row_p1 < nr) begin
                     row_in = row_p1[RW-1:0];
                  end
                  res_load = 1'b1;
               end
               OP_READ: begin
                  // cells of a cleared row or outside the store read as blank
                  mem_raddr = {rd_row_t, rd_col_t};
                  if (!rd_hit) begin
                     res_load = 1'b1;
                     res_rd   = BLANK;
                  end
               end
               default: begin
                  res_load = 1'b1;
               end
            endcase
         end
         ST_TAB: begin
            mem_we = 1'b1;
            col_in = adv_col;
            row_in = adv_row;
            len_in = len_ff + (CW+1)'(1);
            if (tab_end) begin
               res_load = 1'b1;
               res_sv   = 1'b1;
               res_srow = span_row_ff;
               res_scol = span_col_ff;
               res_slen = len_ff + (CW+1)'(1);
            end
         end
         ST_DEL: begin
            // read one cell ahead, write it one place left when its registered read data returns
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = {row_ff, dst_ff};
               mem_wdata = rdata_ff;
            end
            if (src_ff < nc) begin
               mem_raddr = {row_ff, src_ff[CW-1:0]};
               dst_in    = src_ff[CW-1:0] - CW'(1);
               src_in    = src_ff + (CW+1)'(1);
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
         end
         ST_DEL_END: begin
            mem_we    = 1'b1;
            mem_waddr = {row_ff, CW'(nc - (CW+1)'(1))};
            res_load  = 1'b1;
            res_sv    = 1'b1;
            res_srow  = span_row_ff;
            res_scol  = span_col_ff;
            res_slen  = nc - {1'b0, span_col_ff};
         end
         ST_READ: begin
            res_load = 1'b1;
            res_rd   = rdata_ff;
         end
         default: begin
         end
      endcase

      // Column and row register writes resize the grid: wipe and home
      if (csr_valid && csr_ready && (csr_index == REG_COLUMNS)) begin
         columns_in = csr_data;
      end
      if (csr_valid && csr_ready && (csr_index == REG_ROWS)) begin
         rows_in = csr_data[6:0];
      end
      if (cfg_hit) begin
         rv_in  = '0;
         col_in = '0;
         row_in = '0;
      end

      // Output register
      rsp_in = rsp_ff;
      if (res_load) begin
         rsp_in.span_valid = res_sv;
         rsp_in.span_row   = 6'(res_srow);
         rsp_in.span_col   = 7'(res_scol);
         rsp_in.span_len   = 8'(res_slen);
         rsp_in.clear_all  = res_clr;
         rsp_in.caret_col  = 7'(col_in);
         rsp_in.caret_row  = 6'(row_in);
         rsp_in.read_char  = res_rd;
      end
      if (res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rv_ff        <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         columns_ff   <= COLUMNS_RESET;
         rows_ff      <= ROWS_RESET;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rv_ff        <= rv_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         columns_ff   <= columns_in;
         rows_ff      <= rows_in;
         pend_ff      <= pend_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      fill_ff     <= fill_in;
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      span_row_ff <= span_row_in;
      span_col_ff <= span_col_in;
      len_ff      <= len_in;
      rsp_ff      <= rsp_in;
   end

   // Cell store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= cell_mem[mem_raddr];
   end

endmodule

// ===== rtl/core/text_cell_buffer_with_caret.sv =====
// Character-cell text buffer with a caret for a simple typing console.
// req_* carries one key event per beat: tuser holds the command (character,
// navigation key, clear, read cell), tdata the character, key and read cell.
// rsp_* returns exactly one beat per event, with tlast always set: the
// changed span of one row, a whole-buffer clear flag, the caret after the
// event and the cell read back. csr_* writes the column and row counts;
// a write there blanks the buffer and homes the caret, and is taken only
// while no event is in flight.
// A decoder and a two-entry queue take events while the executor works;
// the executor owns the caret, the cell store and the result register.
// Events run one at a time, each through a check and a run state: a tab
// then writes blanks up to the next stop, a read of a written row adds a
// state for the registered store read, and delete and backspace move one
// cell per cycle through the store's single write port. The first write
// to a row after a clear blanks that row first. The executor takes no new
// event until the last has its result, so a back-to-back sender sees req_tready drop.
// Reset empties the queue, homes the caret, sets 80 columns by 25 rows and
// makes every cell read as a space with no sweep. While rsp_tready is low
// the result is held, the executor stops before its next event and the
// queue fills, then req_tready drops.
module text_cell_buffer_with_caret #(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64,
   parameter int TAB_STOP = 8
) (
   input  logic        clock,
   input  logic        reset,
   // input beats
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] command
   input  logic [31:0] req_tdata,   // char_code[7:0], key_code[11:8],
                                    // read_col[18:12], read_row[24:19], zero above
   // result beats
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // span_valid[0], clear_all[1]
   output logic [47:0] rsp_tdata,   // span_row[5:0], span_col[12:6], span_len[20:13],
                                    // caret_col[27:21], caret_row[33:28],
                                    // read_char[41:34], zero above
   output logic        rsp_tlast,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import tcb_pkg::*;

   logic    push;
   op_type  push_op;
   logic    q_full;
   logic    q_valid;
   logic    q_pop;
   op_type  q_op;
   rsp_type rsp;

   tcb_front u_front (
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .req_tready (req_tready),
      .q_full     (q_full),
      .push       (push),
      .push_op    (push_op)
   );

   tcb_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (q_pop),
      .full    (q_full),
      .valid   (q_valid),
      .head    (q_op)
   );

   tcb_back #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS),
      .TAB_STOP (TAB_STOP)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .csr_ready (csr_ready),
      .q_valid   (q_valid),
      .q_op      (q_op),
      .q_pop     (q_pop),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp       (rsp)
   );

   // Result beat packing; every event yields a single beat
   assign rsp_tuser = {rsp.clear_all, rsp.span_valid};
   assign rsp_tdata = {6'd0, rsp.read_char, rsp.caret_row, rsp.caret_col,
                       rsp.span_len, rsp.span_col, rsp.span_row};
   assign rsp_tlast = 1'b1;

endmodule
